### src/kpl_pkg.sv
`timescale 1ns / 1ps
// Shared constants, key map and verdict codes for the keypad combination lock.
package kpl_pkg;

    localparam logic [15:0] PASSWORD_RESET = 16'd5892;
    localparam logic [3:0]  EQUALS_KEY     = 4'd11;

    typedef enum logic [1:0] {
        VERDICT_NONE      = 2'd0,
        VERDICT_CORRECT   = 2'd1,
        VERDICT_INCORRECT = 2'd2
    } verdict_t;

    // Active-low drive pattern for each column.
    function automatic logic [3:0] col_pattern(input logic [1:0] col);
        logic [3:0] pat;
        unique case (col)
            2'd0: pat = 4'hE;
            2'd1: pat = 4'hD;
            2'd2: pat = 4'hB;
            2'd3: pat = 4'h7;
            default: pat = 4'hE;
        endcase
        return pat;
    endfunction

    // Key code for a column and a row.
    function automatic logic [3:0] key_map(input logic [1:0] col, input logic [1:0] row);
        logic [3:0] code;
        unique case ({col, row})
            4'h0: code = 4'd7;
            4'h1: code = 4'd4;
            4'h2: code = 4'd1;
            4'h3: code = 4'd10;
            4'h4: code = 4'd8;
            4'h5: code = 4'd5;
            4'h6: code = 4'd2;
            4'h7: code = 4'd0;
            4'h8: code = 4'd9;
            4'h9: code = 4'd6;
            4'hA: code = 4'd3;
            4'hB: code = 4'd11;
            4'hC: code = 4'd12;
            4'hD: code = 4'd13;
            4'hE: code = 4'd14;
            4'hF: code = 4'd15;
            default: code = 4'd0;
        endcase
        return code;
    endfunction

endpackage

### src/keypad_scan_password_lock.sv
`timescale 1ns / 1ps
// Keypad scanner with combination lock: input register, scan/lock logic, result register.
//
// Usage:
//   Input channel (in_valid / in_stall / row_lines): one word per scan tick,
//   the active-low row lines sampled under the column last shown on
//   column_drive. Output channel (out_valid / out_stall / result fields):
//   one result word per input word, in order.
//   Config channel (cfg_valid / cfg_ready / password_value): cfg_ready is
//   always high; write the password only while the block is idle.
// Pipeline: an accepted word passes through the input register and then the
//   result register, where it waits to be taken (one input register, one result
//   register).
// Throughput: one word per cycle while out_stall is low; the scan and entry update is a single
//   combinational pass between the two registers.
// Stall: out_stall holds the result register and, when the input register is
//   also full, raises in_stall at once; no word is lost or repeated.
// Reset: scan restarts at the first column, entry and lock state clear,
//   password returns to 5892, both pipeline registers empty.
// Once unlocked, the scan and entry freeze until reset and every result
//   reports verdict correct.
module keypad_scan_password_lock
    import kpl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  row_lines,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  column_drive,
    output logic        key_valid,
    output logic [3:0]  key_code,
    output logic [15:0] entry_value,
    output logic [1:0]  verdict,
    output logic        unlocked,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] password_value
);

    logic [15:0] password_reg;

    logic        s1_valid_reg;
    logic [3:0]  s1_rows_reg;
    logic        s1_move;

    logic [1:0]  col_reg,      col_next;
    logic        waiting_reg,  waiting_next;
    logic [3:0]  held_rows_reg, held_rows_next;
    logic [3:0]  held_key_reg, held_key_next;
    logic [15:0] entry_reg,    entry_next;
    logic        open_reg,     open_next;

    logic        out_valid_reg;
    logic [3:0]  column_drive_reg;
    logic        key_valid_reg;
    logic [3:0]  key_code_reg;
    logic [15:0] entry_value_reg;
    verdict_t    verdict_reg;

    logic        res_key_valid;
    logic [3:0]  res_key_code;
    verdict_t    res_verdict;

    logic        single_low;
    logic [1:0]  low_row;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            password_reg <= PASSWORD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            password_reg <= password_value;
        end
    end

    // Advance the input register into the result register when the latter frees up.
    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_rows_reg <= row_lines;
        end
    end

    always_comb
    begin
        single_low = 1'b1;
        low_row    = 2'd0;
        unique case (s1_rows_reg)
            4'hE: low_row = 2'd0;
            4'hD: low_row = 2'd1;
            4'hB: low_row = 2'd2;
            4'h7: low_row = 2'd3;
            default: single_low = 1'b0;
        endcase
    end

    always_comb
    begin
        col_next       = col_reg;
        waiting_next   = waiting_reg;
        held_rows_next = held_rows_reg;
        held_key_next  = held_key_reg;
        entry_next     = entry_reg;
        open_next      = open_reg;
        res_key_valid  = 1'b0;
        res_key_code   = 4'd0;
        res_verdict    = VERDICT_NONE;
        priority if (open_reg)
        begin
            res_verdict = VERDICT_CORRECT;
        end
        else if (!waiting_reg)
        begin
            if (single_low)
            begin
                held_key_next  = key_map(col_reg, low_row);
                held_rows_next = s1_rows_reg;
                waiting_next   = 1'b1;
            end
            else
            begin
                col_next = col_reg + 2'd1;
            end
        end
        else if (s1_rows_reg != held_rows_reg)
        begin
            // Release: report the held key and restart the scan.
            res_key_valid = 1'b1;
            res_key_code  = held_key_reg;
            waiting_next  = 1'b0;
            col_next      = 2'd0;
            if (held_key_reg == EQUALS_KEY)
            begin
                if (entry_reg == password_reg)
                begin
                    open_next   = 1'b1;
                    res_verdict = VERDICT_CORRECT;
                end
                else
                begin
                    entry_next  = 16'd0;
                    res_verdict = VERDICT_INCORRECT;
                end
            end
            else
            begin
                entry_next = (entry_reg << 3) + (entry_reg << 1) + {12'd0, held_key_reg};
            end
        end
        else
        begin
            // Same pattern while the key is down: keep waiting.
            waiting_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= 2'd0;
            waiting_reg   <= 1'b0;
            held_rows_reg <= 4'd0;
            held_key_reg  <= 4'd0;
            entry_reg     <= 16'd0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_move)
            begin
                col_reg       <= col_next;
                waiting_reg   <= waiting_next;
                held_rows_reg <= held_rows_next;
                held_key_reg  <= held_key_next;
                entry_reg     <= entry_next;
                open_reg      <= open_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            column_drive_reg <= col_pattern(col_next);
            key_valid_reg    <= res_key_valid;
            key_code_reg     <= res_key_code;
            entry_value_reg  <= entry_next;
            verdict_reg      <= res_verdict;
        end
    end

    assign out_valid    = out_valid_reg;
    assign column_drive = column_drive_reg;
    assign key_valid    = key_valid_reg;
    assign key_code     = key_code_reg;
    assign entry_value  = entry_value_reg;
    assign verdict      = verdict_reg;
    assign unlocked     = open_reg;

    // Once open, the lock stays open until reset.
    a_open_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |=> open_reg)
        else $error("lock relocked without reset");

    // An open lock always reports the correct verdict.
    a_open_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && open_reg) |-> (verdict_reg == VERDICT_CORRECT))
        else $error("open lock reported a wrong verdict");

    // No key code without a release.
    a_code_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !key_valid_reg) |-> (key_code_reg == 4'd0))
        else $error("key code without release");

    // Exactly one column is driven low.
    a_one_column: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($countones(~column_drive_reg) == 1))
        else $error("column drive not one-cold");

    // The scan state moves only with a word leaving the input register.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_move |=> ($stable(col_reg) && $stable(entry_reg) && $stable(waiting_reg)))
        else $error("scan state changed without a word");

endmodule
